// ===== sv/ovle_pkg.sv =====
package ovle_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ACT_W     = 3;
    localparam int VAL_W     = 32;
    localparam int MCNT_W    = 5;
    localparam int COUNT_MAX = 31;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT     = 3'd0,
        ACT_UPDATE     = 3'd1,
        ACT_REMOVE_ONE = 3'd2,
        ACT_REMOVE_ALL = 3'd3,
        ACT_SEARCH     = 3'd4
    } action_t;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] new_value;
    } ovle_req_t;

    typedef struct packed {
        logic              hit;
        logic [MCNT_W-1:0] match_count;
    } ovle_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic insert;
        logic scan;
        logic commit;
        logic out_load;
    } ovle_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ovle_status_t;

endpackage

// ===== sv/ovle_ctrl.sv =====
module ovle_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic [ovle_pkg::ACT_W-1:0]    action,
    input  ovle_pkg::ovle_status_t        status,
    output logic                          req_stall,
    output ovle_pkg::ovle_cmd_t           cmd
);
    import ovle_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (action == ACT_INSERT)
                    begin
                        state_next = ST_INSERT;
                    end
                    else if (action inside {ACT_UPDATE, ACT_REMOVE_ONE,
                                            ACT_REMOVE_ALL, ACT_SEARCH})
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        // unknown action: no change, empty result
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the result register can take the result
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ovle_dp.sv =====
module ovle_dp #(
    parameter int DEPTH = ovle_pkg::DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ovle_pkg::ovle_req_t     req,
    input  ovle_pkg::ovle_cmd_t     cmd,
    input  logic                    rsp_stall,
    output ovle_pkg::ovle_status_t  status,
    output logic                    rsp_valid,
    output ovle_pkg::ovle_rsp_t     rsp
);
    import ovle_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // list storage, circular with the head at head_reg
    logic [VAL_W-1:0] mem [DEPTH];

    logic [ACT_W-1:0] act_reg;
    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] nval_reg;
    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] w_idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic             found_reg;
    logic             pend_reg;
    logic [VAL_W-1:0] rd_data_reg;
    logic             rsp_valid_reg;
    ovle_rsp_t        rsp_reg;
    ovle_rsp_t        rsp_next;

    logic             issue;
    logic             match;
    logic             keep;
    logic             scan_wr;
    logic             bump;
    logic             set_found;
    logic [VAL_W-1:0] scan_wdata;
    logic             full;
    logic [IDX_W-1:0] new_head;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [VAL_W-1:0] wdata;
    logic [31:0]      count_wide;
    logic [MCNT_W-1:0] count_sat;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] idx);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, idx[IDX_W-1:0]};
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign issue    = cmd.scan && (rd_idx_reg < fill_reg);
    assign match    = pend_reg && (rd_data_reg == val_reg);
    assign raddr    = phys(head_reg, rd_idx_reg);
    assign full     = (fill_reg == DEPTH_C);
    assign new_head = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;

    // one entry per cycle: read at rd_idx; update and removals write the survivor back at w_idx
    always_comb
    begin
        keep       = 1'b1;
        scan_wr    = 1'b0;
        bump       = 1'b0;
        set_found  = 1'b0;
        scan_wdata = rd_data_reg;
        case (act_reg)
            ACT_UPDATE:
            begin
                scan_wr = 1'b1;
                bump    = match;
                if (match)
                begin
                    scan_wdata = nval_reg;
                end
            end
            ACT_REMOVE_ONE:
            begin
                set_found = match && !found_reg;
                keep      = !set_found;
                scan_wr   = keep;
            end
            ACT_REMOVE_ALL:
            begin
                keep    = !match;
                scan_wr = keep;
                bump    = match;
            end
            ACT_SEARCH:
            begin
                set_found = match;
            end
            default:
            begin
                keep = 1'b1;
            end
        endcase
        if (!(cmd.scan && pend_reg))
        begin
            keep      = 1'b0;
            scan_wr   = 1'b0;
            bump      = 1'b0;
            set_found = 1'b0;
        end
    end

    always_comb
    begin
        if (cmd.insert)
        begin
            we    = !full;
            waddr = new_head;
            wdata = val_reg;
        end
        else
        begin
            we    = scan_wr;
            waddr = phys(head_reg, w_idx_reg);
            wdata = scan_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= req.action;
            val_reg  <= req.value;
            nval_reg <= req.new_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            fill_reg   <= '0;
            rd_idx_reg <= '0;
            w_idx_reg  <= '0;
            count_reg  <= '0;
            found_reg  <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_idx_reg <= '0;
                w_idx_reg  <= '0;
                count_reg  <= '0;
                found_reg  <= 1'b0;
                pend_reg   <= 1'b0;
            end
            if (cmd.scan)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (keep)
                begin
                    w_idx_reg <= w_idx_reg + 1'b1;
                end
                if (bump)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (set_found)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.insert && !full)
            begin
                head_reg  <= new_head;
                fill_reg  <= fill_reg + 1'b1;
                found_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                fill_reg <= w_idx_reg;
            end
        end
    end

    assign count_wide = 32'(count_reg);
    assign count_sat  = (count_wide > 32'(COUNT_MAX)) ? MCNT_W'(COUNT_MAX)
                                                      : count_wide[MCNT_W-1:0];

    always_comb
    begin
        rsp_next = '0;
        case (act_reg)
            ACT_INSERT, ACT_REMOVE_ONE, ACT_SEARCH:
            begin
                rsp_next.hit = found_reg;
            end
            ACT_UPDATE, ACT_REMOVE_ALL:
            begin
                rsp_next.hit         = (count_reg != '0);
                rsp_next.match_count = count_sat;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign rsp              = rsp_reg;
    assign status.scan_done = (rd_idx_reg == fill_reg) && !pend_reg;
    assign status.out_free  = !rsp_valid_reg || !rsp_stall;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("fill level beyond list depth");

    a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (w_idx_reg <= rd_idx_reg))
        else $error("compaction write index ahead of read index");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && scan_wr) |-> (raddr != waddr))
        else $error("scan read and write hit the same entry");

    a_commit_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (fill_reg <= $past(fill_reg)))
        else $error("scan pass grew the list");

endmodule

// ===== sv/ordered_value_list_engine_top.sv =====
// Ordered list of up to DEPTH signed 32-bit values, head first, kept in one
// memory with a moving head pointer. Insert fails when the list is full; an
// unknown action leaves the list unchanged and gives an empty result. Update,
// remove-first, remove-all and search walk the whole list through the single
// memory read port, one entry per cycle. One request is in work at a time; the
// result sits in an output register, and req_stall is high while a request is
// in work or its result cannot yet be loaded. match_count saturates at 31.
module ordered_value_list_engine_top #(
    parameter int DEPTH = ovle_pkg::DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  ovle_pkg::ovle_req_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output ovle_pkg::ovle_rsp_t  rsp
);
    import ovle_pkg::*;

    ovle_cmd_t    cmd;
    ovle_status_t status;

    ovle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .action    (req.action),
        .status    (status),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    ovle_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import ovle_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * (LIST_DEPTH + 4);
    localparam int ITEMS_PER_PHASE = 250;
    localparam int MAX_REPORTS  = 20;

    localparam int VAL_MIN = 32'sh8000_0000;
    localparam int VAL_MAX = 32'sh7fff_ffff;

    // action codes outside the defined set; the block must answer them with a miss
    localparam logic [ACT_W-1:0] ACT_BAD_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_BAD_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_BAD_7 = 3'd7;

    typedef struct {
        logic [ACT_W-1:0] act;
        int               value;
        int               new_value;
        int               reps;
        bit               known;
        bit               hit;
        int               cnt;
    } script_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    ovle_req_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    ovle_rsp_t rsp;

    // expectation typed into the directed table, carried along with the request
    logic      known_valid;
    ovle_rsp_t known_rsp;

    int send_pct;
    int recv_pct;
    bit hold_pending;
    int err_count;
    int cycle_count;

    logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
    int unsigned             list_len;
    ovle_rsp_t               expected_q [$];

    script_row_t script [23] = '{
        '{ACT_SEARCH,     0,       0,       1,  1'b1, 1'b0, 0},
        '{ACT_REMOVE_ONE, 0,       0,       1,  1'b1, 1'b0, 0},
        '{ACT_REMOVE_ALL, 0,       0,       1,  1'b1, 1'b0, 0},
        '{ACT_UPDATE,     0,       1,       1,  1'b1, 1'b0, 0},
        '{ACT_BAD_5,      VAL_MAX, VAL_MIN, 1,  1'b1, 1'b0, 0},
        '{ACT_BAD_6,      -1,      -1,      1,  1'b1, 1'b0, 0},
        '{ACT_BAD_7,      VAL_MIN, VAL_MAX, 1,  1'b1, 1'b0, 0},
        '{ACT_INSERT,     VAL_MIN, 0,       1,  1'b1, 1'b1, 0},
        '{ACT_INSERT,     VAL_MAX, -1,      1,  1'b1, 1'b1, 0},
        '{ACT_INSERT,     7,       0,       14, 1'b1, 1'b1, 0},
        '{ACT_INSERT,     0,       0,       1,  1'b1, 1'b0, 0},
        '{ACT_SEARCH,     VAL_MIN, 0,       1,  1'b1, 1'b1, 0},
        '{ACT_UPDATE,     7,       -1,      1,  1'b1, 1'b1, 14},
        '{ACT_REMOVE_ONE, VAL_MAX, 0,       1,  1'b1, 1'b1, 0},
        '{ACT_REMOVE_ALL, -1,      0,       1,  1'b1, 1'b1, 14},
        '{ACT_SEARCH,     7,       0,       1,  1'b1, 1'b0, 0},
        '{ACT_UPDATE,     VAL_MIN, VAL_MAX, 1,  1'b1, 1'b1, 1},
        '{ACT_REMOVE_ONE, VAL_MAX, 0,       1,  1'b1, 1'b1, 0},
        '{ACT_INSERT,     3,       0,       3,  1'b0, 1'b0, 0},
        '{ACT_INSERT,     4,       0,       1,  1'b0, 1'b0, 0},
        '{ACT_REMOVE_ONE, 3,       0,       1,  1'b0, 1'b0, 0},
        '{ACT_UPDATE,     3,       4,       1,  1'b0, 1'b0, 0},
        '{ACT_REMOVE_ALL, 4,       0,       1,  1'b0, 1'b0, 0}
    };

    ordered_value_list_engine_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Apply one request to the shadow list and return the answer it earns.
    task automatic apply_to_list(input ovle_req_t r, output ovle_rsp_t o);
        int unsigned i;
        int unsigned j;
        int unsigned keep;
        int unsigned hits;
        bit          found;
        hits  = 0;
        found = 1'b0;
        case (r.action)
            ACT_INSERT: begin
                if (list_len < LIST_DEPTH) begin
                    for (i = list_len; i > 0; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[0] = r.value;
                    list_len++;
                    found = 1'b1;
                end
            end
            ACT_UPDATE: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == r.value) begin
                        list_mem[i] = r.new_value;
                        hits++;
                    end
                end
                found = (hits > 0);
            end
            ACT_REMOVE_ONE: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == r.value) begin
                        for (j = i; j + 1 < list_len; j++)
                            list_mem[j] = list_mem[j+1];
                        list_len--;
                        found = 1'b1;
                        break;
                    end
                end
            end
            ACT_REMOVE_ALL: begin
                keep = 0;
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == r.value)
                        hits++;
                    else
                    begin
                        list_mem[keep] = list_mem[i];
                        keep++;
                    end
                end
                list_len = keep;
                found = (hits > 0);
            end
            ACT_SEARCH: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == r.value) begin
                        found = 1'b1;
                        break;
                    end
                end
            end
            default: ;
        endcase
        o.hit = found;
        o.match_count = (hits > COUNT_MAX) ? MCNT_W'(COUNT_MAX) : MCNT_W'(hits);
    endtask

    // Mostly a small set of recurring values so that searches and removals hit.
    function automatic int pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return -1;
            3:       return 0;
            4, 5:    return int'($urandom);
            default: return 100 + int'($urandom_range(3));
        endcase
    endfunction

    task automatic random_request(input int insert_pct, output ovle_req_t r);
        int roll;
        roll = int'($urandom_range(99));
        r.value     = pick_value();
        r.new_value = pick_value();
        if (roll < 4)
            r.action = ACT_W'($urandom_range(ACT_BAD_7, ACT_BAD_5));
        else if (roll < 4 + insert_pct)
            r.action = ACT_INSERT;
        else
        begin
            case ($urandom_range(3))
                0:       r.action = ACT_UPDATE;
                1:       r.action = ACT_REMOVE_ONE;
                2:       r.action = ACT_REMOVE_ALL;
                default: r.action = ACT_SEARCH;
            endcase
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input ovle_req_t r, input bit known, input ovle_rsp_t want);
        while (int'($urandom_range(99)) < send_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        req         <= r;
        known_valid <= known;
        known_rsp   <= want;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        @(negedge clk);
    endtask

    // Receiver side: random stall, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_stall <= (int'($urandom_range(99)) < recv_pct);
        end
    end

    always @(posedge clk) begin
        ovle_rsp_t predicted;
        ovle_rsp_t want;
        if (rst_n && req_valid && !req_stall) begin
            apply_to_list(req, predicted);
            expected_q.push_back(known_valid ? known_rsp : predicted);
        end
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: response with nothing expected: hit %0b count %0d",
                             $time, rsp.hit, rsp.match_count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (rsp.hit !== want.hit || rsp.match_count !== want.match_count) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: mismatch: expected hit %0b count %0d, got hit %0b count %0d",
                                 $time, want.hit, want.match_count, rsp.hit, rsp.match_count);
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        ovle_req_t r;
        ovle_rsp_t want;
        int        row;
        int        rep;
        int        phase;
        int        k;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_stall    = 1'b0;
        known_valid  = 1'b0;
        known_rsp    = '0;
        send_pct     = 0;
        recv_pct     = 0;
        hold_pending = 1'b0;
        err_count    = 0;
        list_len     = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < $size(script); row++) begin
            r.action    = script[row].act;
            r.value     = script[row].value;
            r.new_value = script[row].new_value;
            want.hit    = script[row].hit;
            want.match_count = MCNT_W'(script[row].cnt);
            for (rep = 0; rep < script[row].reps; rep++)
                send_request(r, script[row].known, want);
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 80; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 80; end
                default: begin send_pct = 17; recv_pct = 17; end
            endcase
            // sender keeps offering while the receiver holds off, so the block backs up
            if (phase == 0)
                hold_pending = 1'b1;
            // alternate fill-heavy and drain-heavy bursts to swing between empty and full
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                random_request(((k / 40) % 2 == 0) ? 65 : 20, r);
                send_request(r, 1'b0, '0);
            end
        end

        req_valid <= 1'b0;
        recv_pct = 0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ovle_pkg.sv
sv/ovle_ctrl.sv
sv/ovle_dp.sv
sv/ordered_value_list_engine_top.sv
tb/tb.sv
